// ===== rtl/asoi_pkg.sv =====
// ----------------------------------------------------------------------------
// asoi_pkg
// Shared types and constants for the adaptive span output interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package asoi_pkg;

  localparam int NUM_CH = 8;

  localparam int CMD_W  = 2;
  localparam int TIME_W = 32;
  localparam int CH_W   = 3;
  localparam int LVL_W  = 16;
  localparam int GRP_W  = 2;
  localparam int SLOT_W = 3;
  localparam int TICK_W = 16;
  localparam int MAP_W  = 24;

  // span never exceeds four ticks of at most 16 bits
  localparam int SPAN_W = TICK_W + 2;
  localparam int QUOT_W = LVL_W;
  localparam int PROD_W = QUOT_W + SPAN_W;
  localparam int DIV_STEPS = QUOT_W / 2;

  localparam logic [TICK_W-1:0] TICK_RST = 16'd500;
  localparam logic [MAP_W-1:0]  MAP_RST  = 24'hFAC688;
  localparam logic [SPAN_W-1:0] SPAN_RST = SPAN_W'(TICK_RST - TICK_RST / 16);

  localparam logic [CMD_W-1:0] CMD_STAGE  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_COMMIT = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CHUNK  = 2'd2;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_TICK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP  = 1'd1;

  typedef struct packed {
    logic [CMD_W-1:0]        command;
    logic [TIME_W-1:0]       time_us;
    logic [CH_W-1:0]         channel;
    logic signed [LVL_W-1:0] level;
    logic [GRP_W-1:0]        pair_group;
  } cmd_item_t;

  typedef struct packed {
    logic [SLOT_W-1:0]       dac_slot;
    logic signed [LVL_W-1:0] value;
    logic                    last;
  } res_item_t;

  typedef struct packed {
    logic              go;
    logic [PROD_W-1:0] dividend;
    logic [SPAN_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_MUL,
    ST_DIV,
    ST_FIN,
    ST_SPAN_TGT,
    ST_SPAN_UPD
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/asoi_div.sv =====
// ----------------------------------------------------------------------------
// asoi_div
// Iterative unsigned divider, two quotient bits per cycle. The dividend must
// be below divisor * 2^QUOT_W.
// ----------------------------------------------------------------------------
`default_nettype none

module asoi_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire asoi_pkg::div_req_t req,
  output asoi_pkg::div_rsp_t      rsp
);

  localparam int SW = asoi_pkg::SPAN_W;
  localparam int QW = asoi_pkg::QUOT_W;
  localparam int NW = $clog2(asoi_pkg::DIV_STEPS);

  logic          busy;
  logic          done;
  logic [NW-1:0] cnt;
  logic [SW-1:0] rem;
  logic [QW-1:0] low;
  logic [QW-1:0] quot;

  logic [SW:0]   r1;
  logic [SW:0]   r1s;
  logic [SW:0]   r2;
  logic [SW:0]   r2s;
  logic          b1;
  logic          b2;

  always_comb begin
    r1  = {rem, low[QW-1]};
    b1  = (r1 >= {1'b0, req.divisor});
    r1s = b1 ? (r1 - {1'b0, req.divisor}) : r1;
    r2  = {r1s[SW-1:0], low[QW-2]};
    b2  = (r2 >= {1'b0, req.divisor});
    r2s = b2 ? (r2 - {1'b0, req.divisor}) : r2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.go) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == NW'(asoi_pkg::DIV_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      rem <= req.dividend[asoi_pkg::PROD_W-1:QW];
      low <= req.dividend[QW-1:0];
    end else if (busy) begin
      rem  <= r2s[SW-1:0];
      low  <= {low[QW-3:0], 2'b00};
      quot <= {quot[QW-3:0], b1, b2};
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

`default_nettype wire

// ===== rtl/adaptive_span_output_interpolator_top.sv =====
// ----------------------------------------------------------------------------
// adaptive_span_output_interpolator_top
// Per-channel linear ramps between engine ticks, read out per DAC slot pair.
// ----------------------------------------------------------------------------
// One item at a time. A commit or a chunk walks the channels one by one,
// reading the level memory (a commit writes each channel back): a channel
// whose ramp is complete (or a chunk channel outside the pair) goes through
// read, calc and finish (read only when skipped); a channel inside its ramp
// adds the multiply and divide states for one 16x18 multiply and the
// two-bit-per-cycle divider. A commit adds the span target and span update
// states; a chunk may stall in finish on the result port. A result beat
// waits in the output register while the next channel is being worked.
// ----------------------------------------------------------------------------
`default_nettype none

module adaptive_span_output_interpolator_top #(
  parameter int NUM_CHANNELS = asoi_pkg::NUM_CH
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cmd_valid,
  output logic                                    cmd_stall,
  input  wire asoi_pkg::cmd_item_t                cmd,
  output logic                                    res_valid,
  input  wire logic                               res_stall,
  output asoi_pkg::res_item_t                     res,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [asoi_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [asoi_pkg::MAP_W-1:0]         cfg_data
);

  localparam int CW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int LW = asoi_pkg::LVL_W;
  localparam int SW = asoi_pkg::SPAN_W;
  localparam int TW = asoi_pkg::TIME_W;
  localparam int KW = asoi_pkg::TICK_W;
  localparam int PW = asoi_pkg::PROD_W;
  localparam int ZW = asoi_pkg::SLOT_W;

  asoi_pkg::state_t state;
  asoi_pkg::state_t state_next;

  logic [KW-1:0]                 tick;
  logic [asoi_pkg::MAP_W-1:0]    dac_map;
  logic [SW-1:0]                 span;
  logic [SW-1:0]                 span_adj_next;
  logic [TW-1:0]                 origin;
  logic                          started;
  logic [CW-1:0]                 ch_cnt;
  logic [NUM_CHANNELS-1:0]       vld_a;
  logic [NUM_CHANNELS-1:0]       vld_b;

  logic [2*LW-1:0]               mem_a [NUM_CHANNELS];
  logic [LW-1:0]                 mem_b [NUM_CHANNELS];
  logic [2*LW-1:0]               rd_a;
  logic [LW-1:0]                 rd_b;
  logic                          rd_a_ok;
  logic                          rd_b_ok;

  logic [TW-1:0]                 now_r;
  logic [TW-1:0]                 seen_r;
  logic [SW-1:0]                 el_r;
  logic                          full_r;
  logic                          chunk_r;
  logic [NUM_CHANNELS-1:0]       mask_r;
  logic [PW-1:0]                 prod_r;
  logic                          neg_r;
  logic [LW-1:0]                 slev_r;
  logic [LW-1:0]                 tlev_r;
  logic [LW-1:0]                 stg_r;
  logic [SW-1:0]                 tgt_r;

  logic                          accept;
  logic                          ch_ok;
  logic                          wr_a;
  logic                          wr_b;
  logic                          res_free;
  logic                          fin_go;
  logic                          res_load;
  logic                          skip;
  logic                          adv;
  logic                          last_ch;
  logic                          span_upd;

  logic [TW-1:0]                 seen_c;
  logic                          seen_ge;
  logic [NUM_CHANNELS-1:0]       mask_c;
  logic [LW-1:0]                 slev_c;
  logic [LW-1:0]                 tlev_c;
  logic signed [LW:0]            diff_c;
  logic [LW:0]                   mag_c;
  logic signed [LW:0]            sq_c;
  logic signed [LW:0]            val_c;
  logic [NUM_CHANNELS-1:0]       rest_c;
  logic                          last_res;
  logic [TW-1:0]                 tgt32_c;
  logic [TW-1:0]                 lo_c;
  logic [TW-1:0]                 hi_c;
  logic [KW-1:0]                 dflt_c;
  logic [SW-1:0]                 tgt_c;
  logic [SW-1:0]                 gap_c;
  logic [SW:0]                   inc_c;

  asoi_pkg::div_req_t            div_req;
  asoi_pkg::div_rsp_t            div_rsp;

  asoi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  // accept-time decode
  always_comb begin
    seen_c  = cmd.time_us - origin;
    seen_ge = (seen_c >= TW'(span));
    ch_ok   = ({1'b0, cmd.channel} < (asoi_pkg::CH_W + 1)'(NUM_CHANNELS));
    for (int c = 0; c < NUM_CHANNELS; c++) begin
      mask_c[c] = (dac_map[ZW*c+1 +: 2] == cmd.pair_group);
    end
  end

  // per-channel datapath
  always_comb begin
    slev_c   = rd_a_ok ? rd_a[2*LW-1:LW] : '0;
    tlev_c   = rd_a_ok ? rd_a[LW-1:0] : '0;
    diff_c   = $signed({tlev_c[LW-1], tlev_c}) - $signed({slev_c[LW-1], slev_c});
    mag_c    = diff_c[LW] ? (LW+1)'(-diff_c) : diff_c;
    sq_c     = neg_r ? -$signed({1'b0, div_rsp.quot}) : $signed({1'b0, div_rsp.quot});
    val_c    = full_r ? $signed({tlev_r[LW-1], tlev_r})
                      : $signed({slev_r[LW-1], slev_r}) + sq_c;
    rest_c   = mask_r >> ch_cnt;
    last_res = ((rest_c >> 1) == '0);
    last_ch  = (ch_cnt == CW'(NUM_CHANNELS - 1));
  end

  // span adaptation
  always_comb begin
    tgt32_c = seen_r - (seen_r >> 4);
    lo_c    = TW'(tick >> 2);
    hi_c    = TW'(tick) << 2;
    dflt_c  = tick - (tick >> 4);
    if (!started) begin
      tgt_c = SW'(dflt_c);
    end else if (tgt32_c < lo_c) begin
      tgt_c = lo_c[SW-1:0];
    end else if (tgt32_c > hi_c) begin
      tgt_c = hi_c[SW-1:0];
    end else begin
      tgt_c = tgt32_c[SW-1:0];
    end
    gap_c = tgt_r - span;
    inc_c = {1'b0, span} + (SW+1)'(gap_c >> 6) + 1'b1;
    if (tgt_r > span) begin
      span_adj_next = (inc_c > {1'b0, tgt_r}) ? tgt_r : inc_c[SW-1:0];
    end else begin
      span_adj_next = tgt_r;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      asoi_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd.command)
            asoi_pkg::CMD_COMMIT, asoi_pkg::CMD_CHUNK: state_next = asoi_pkg::ST_READ;
            default: state_next = asoi_pkg::ST_IDLE;
          endcase
        end
      end
      asoi_pkg::ST_READ: begin
        if (skip) begin
          state_next = last_ch ? asoi_pkg::ST_IDLE : asoi_pkg::ST_READ;
        end else begin
          state_next = asoi_pkg::ST_CALC;
        end
      end
      asoi_pkg::ST_CALC: state_next = full_r ? asoi_pkg::ST_FIN : asoi_pkg::ST_MUL;
      asoi_pkg::ST_MUL:  state_next = asoi_pkg::ST_DIV;
      asoi_pkg::ST_DIV: begin
        if (div_rsp.done) begin
          state_next = asoi_pkg::ST_FIN;
        end
      end
      asoi_pkg::ST_FIN: begin
        if (fin_go) begin
          if (!last_ch) begin
            state_next = asoi_pkg::ST_READ;
          end else begin
            state_next = chunk_r ? asoi_pkg::ST_IDLE : asoi_pkg::ST_SPAN_TGT;
          end
        end
      end
      asoi_pkg::ST_SPAN_TGT: state_next = asoi_pkg::ST_SPAN_UPD;
      asoi_pkg::ST_SPAN_UPD: state_next = asoi_pkg::ST_IDLE;
      default: state_next = asoi_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    cmd_stall        = (state != asoi_pkg::ST_IDLE);
    cfg_ready        = 1'b1;
    accept           = cmd_valid && !cmd_stall;
    wr_b             = accept && (cmd.command == asoi_pkg::CMD_STAGE) && ch_ok;
    res_free         = !res_valid || !res_stall;
    fin_go           = (state == asoi_pkg::ST_FIN) && (!chunk_r || res_free);
    wr_a             = fin_go && !chunk_r;
    res_load         = fin_go && chunk_r;
    skip             = (state == asoi_pkg::ST_READ) && chunk_r && !mask_r[ch_cnt];
    adv              = (skip || fin_go) && !last_ch;
    span_upd         = (state == asoi_pkg::ST_SPAN_UPD);
    div_req.go       = (state == asoi_pkg::ST_MUL);
    div_req.dividend = prod_r;
    div_req.divisor  = span;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= asoi_pkg::ST_IDLE;
      ch_cnt    <= '0;
      tick      <= asoi_pkg::TICK_RST;
      dac_map   <= asoi_pkg::MAP_RST;
      span      <= asoi_pkg::SPAN_RST;
      origin    <= '0;
      started   <= 1'b0;
      vld_a     <= '0;
      vld_b     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          asoi_pkg::REG_TICK: tick    <= cfg_data[KW-1:0];
          asoi_pkg::REG_MAP:  dac_map <= cfg_data;
          default: ;
        endcase
      end
      if (accept) begin
        ch_cnt <= '0;
      end else if (adv) begin
        ch_cnt <= ch_cnt + 1'b1;
      end
      if (wr_a) begin
        vld_a[ch_cnt] <= 1'b1;
      end
      if (wr_b) begin
        vld_b[cmd.channel[CW-1:0]] <= 1'b1;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      if (span_upd) begin
        span    <= span_adj_next;
        origin  <= now_r;
        started <= 1'b1;
      end
    end
  end

  // level memories: {start, target} and staged
  always_ff @(posedge clk) begin
    if (wr_a) begin
      mem_a[ch_cnt] <= {val_c[LW-1:0], stg_r};
    end
    if (wr_b) begin
      mem_b[cmd.channel[CW-1:0]] <= cmd.level;
    end
    rd_a    <= mem_a[ch_cnt];
    rd_b    <= mem_b[ch_cnt];
    rd_a_ok <= vld_a[ch_cnt];
    rd_b_ok <= vld_b[ch_cnt];
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      now_r   <= cmd.time_us;
      seen_r  <= seen_c;
      el_r    <= seen_ge ? span : seen_c[SW-1:0];
      full_r  <= seen_ge || ((cmd.command == asoi_pkg::CMD_COMMIT) && !started);
      chunk_r <= (cmd.command == asoi_pkg::CMD_CHUNK);
      mask_r  <= mask_c;
    end
    if (state == asoi_pkg::ST_CALC) begin
      prod_r <= PW'(mag_c[LW-1:0]) * PW'(el_r);
      neg_r  <= diff_c[LW];
      slev_r <= slev_c;
      tlev_r <= tlev_c;
      stg_r  <= rd_b_ok ? rd_b : '0;
    end
    if (state == asoi_pkg::ST_SPAN_TGT) begin
      tgt_r <= tgt_c;
    end
    if (res_load) begin
      res.dac_slot <= dac_map[ZW*ch_cnt +: ZW];
      res.value    <= val_c[LW-1:0];
      res.last     <= last_res;
    end
  end

  // divider completes only while the sequencer waits on it
  assert property (@(posedge clk) disable iff (rst)
    div_rsp.done |-> (state == asoi_pkg::ST_DIV))
    else $error("divider result outside divide wait");

  // a new result beat only comes out of a chunk channel finish
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == asoi_pkg::ST_FIN) && $past(chunk_r))
    else $error("result beat without chunk finish");

  // a finished commit always leaves the ramp started
  assert property (@(posedge clk) disable iff (rst)
    (state == asoi_pkg::ST_SPAN_UPD) |=> started && (state == asoi_pkg::ST_IDLE))
    else $error("commit did not complete span update");

  // level memory written only by a commit pass
  assert property (@(posedge clk) disable iff (rst)
    wr_a |-> !chunk_r && (ch_cnt <= CW'(NUM_CHANNELS - 1)))
    else $error("level memory written outside commit");

endmodule

`default_nettype wire
